@@ hdl/segint_pkg.sv @@
// shared codes and control types for the segment intersection block
`timescale 1ns / 1ps

package segint_pkg;

  // number of common points reported with a result
  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_ONE  = 2'd1;
  localparam logic [1:0] HIT_TWO  = 2'd2;

  // control that travels with an item down the pipeline
  typedef struct packed {
    logic       valid;
    logic       use_div;
    logic [1:0] count;
  } segint_ctl_t;

endpackage

@@ hdl/segint_prep.sv @@
// front stages: differences, cross products, classification and collinear overlap
`timescale 1ns / 1ps

module segint_prep #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [COORD_BITS-1:0]        a_start_x,
  input  logic signed [COORD_BITS-1:0]        a_start_y,
  input  logic signed [COORD_BITS-1:0]        a_end_x,
  input  logic signed [COORD_BITS-1:0]        a_end_y,
  input  logic signed [COORD_BITS-1:0]        b_start_x,
  input  logic signed [COORD_BITS-1:0]        b_start_y,
  input  logic signed [COORD_BITS-1:0]        b_end_x,
  input  logic signed [COORD_BITS-1:0]        b_end_y,
  output segint_pkg::segint_ctl_t             ctl,
  output logic signed [2*COORD_BITS+2:0]      m,
  output logic signed [2*COORD_BITS+2:0]      n1,
  output logic signed [COORD_BITS:0]          dax,
  output logic signed [COORD_BITS:0]          day,
  output logic signed [COORD_BITS-1:0]        ax0,
  output logic signed [COORD_BITS-1:0]        ay0,
  output logic signed [COORD_BITS-1:0]        fx,
  output logic signed [COORD_BITS-1:0]        fy,
  output logic signed [COORD_BITS-1:0]        sx,
  output logic signed [COORD_BITS-1:0]        sy
);

  localparam int C  = COORD_BITS;
  localparam int D  = C + 1;
  localparam int P  = 2 * D;
  localparam int MW = P + 1;

  // stage 1 registers
  logic                v1_r;
  logic signed [C-1:0] ax0_r, ay0_r, ax1_r, ay1_r, bx0_r, by0_r, bx1_r, by1_r;
  logic signed [D-1:0] dax1_r, day1_r, dbx_r, dby_r, ex_r, ey_r;
  logic signed [D-1:0] cx0_r, cy1_r, cx1_r, cy0_r;

  // stage 2 registers
  logic                v2_r;
  logic signed [P-1:0] pm1_r, pm2_r, pn1a_r, pn1b_r, pn2a_r, pn2b_r, pc1_r, pc2_r;
  logic signed [D-1:0] dax2_r, day2_r;
  logic signed [C-1:0] ax02_r, ay02_r;
  logic [1:0]          ccnt_r;
  logic signed [C-1:0] cfx_r, cfy_r, csx_r, csy_r;

  // stage 3 registers
  segint_pkg::segint_ctl_t ctl_r;
  logic signed [MW-1:0]    m_r, n1_r;
  logic signed [D-1:0]     dax3_r, day3_r;
  logic signed [C-1:0]     ax03_r, ay03_r;
  logic signed [C-1:0]     fx_r, fy_r, sx_r, sy_r;

  // collinear overlap from stage 1 coordinates
  logic                usex, aswap, bswap, a_lo, a_hi;
  logic signed [C-1:0] ka0, ka1, kb0, kb1, alk, ahk, blk, bhk, lok, hik;
  logic signed [C-1:0] lox, loy, hix, hiy;
  logic [1:0]          ccnt_nxt;
  logic signed [C-1:0] cfx_nxt, cfy_nxt, csx_nxt, csy_nxt;

  // stage 3 classification
  logic signed [MW-1:0]    m_nxt, n1_nxt, n2_nxt;
  logic                    coll, miss;
  segint_pkg::segint_ctl_t ctl_nxt;
  logic signed [C-1:0]     fx_nxt, fy_nxt, sx_nxt, sy_nxt;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      ctl_r <= '0;
    end else if (en) begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      ctl_r <= ctl_nxt;
    end
  end

  // stage 1: capture and differences
  always_ff @(posedge clk) begin
    if (en) begin
      ax0_r  <= a_start_x;
      ay0_r  <= a_start_y;
      ax1_r  <= a_end_x;
      ay1_r  <= a_end_y;
      bx0_r  <= b_start_x;
      by0_r  <= b_start_y;
      bx1_r  <= b_end_x;
      by1_r  <= b_end_y;
      dax1_r <= D'(a_end_x) - D'(a_start_x);
      day1_r <= D'(a_end_y) - D'(a_start_y);
      dbx_r  <= D'(b_end_x) - D'(b_start_x);
      dby_r  <= D'(b_end_y) - D'(b_start_y);
      ex_r   <= D'(b_start_x) - D'(a_start_x);
      ey_r   <= D'(b_start_y) - D'(a_start_y);
      cx0_r  <= D'(a_start_x) - D'(b_start_x);
      cy1_r  <= D'(a_end_y) - D'(b_start_y);
      cx1_r  <= D'(a_end_x) - D'(b_start_x);
      cy0_r  <= D'(a_start_y) - D'(b_start_y);
    end
  end

  // key selection and interval ends
  always_comb begin
    usex  = (dax1_r != '0);
    ka0   = usex ? ax0_r : ay0_r;
    ka1   = usex ? ax1_r : ay1_r;
    kb0   = usex ? bx0_r : by0_r;
    kb1   = usex ? bx1_r : by1_r;
    aswap = ka1 < ka0;
    bswap = kb1 < kb0;
    alk   = aswap ? ka1 : ka0;
    ahk   = aswap ? ka0 : ka1;
    blk   = bswap ? kb1 : kb0;
    bhk   = bswap ? kb0 : kb1;
    a_lo  = alk >= blk;
    a_hi  = ahk <= bhk;
    lok   = a_lo ? alk : blk;
    hik   = a_hi ? ahk : bhk;
    if (a_lo) begin
      lox = aswap ? ax1_r : ax0_r;
      loy = aswap ? ay1_r : ay0_r;
    end else begin
      lox = bswap ? bx1_r : bx0_r;
      loy = bswap ? by1_r : by0_r;
    end
    if (a_hi) begin
      hix = aswap ? ax0_r : ax1_r;
      hiy = aswap ? ay0_r : ay1_r;
    end else begin
      hix = bswap ? bx0_r : bx1_r;
      hiy = bswap ? by0_r : by1_r;
    end
    ccnt_nxt = segint_pkg::HIT_NONE;
    cfx_nxt  = '0;
    cfy_nxt  = '0;
    csx_nxt  = '0;
    csy_nxt  = '0;
    priority if (lok == hik) begin
      ccnt_nxt = segint_pkg::HIT_ONE;
      cfx_nxt  = lox;
      cfy_nxt  = loy;
    end else if (lok < hik) begin
      ccnt_nxt = segint_pkg::HIT_TWO;
      cfx_nxt  = lox;
      cfy_nxt  = loy;
      csx_nxt  = hix;
      csy_nxt  = hiy;
    end
  end

  // stage 2: cross products
  always_ff @(posedge clk) begin
    if (en) begin
      pm1_r  <= dax1_r * dby_r;
      pm2_r  <= day1_r * dbx_r;
      pn1a_r <= ex_r * dby_r;
      pn1b_r <= dbx_r * ey_r;
      pn2a_r <= ex_r * day1_r;
      pn2b_r <= dax1_r * ey_r;
      pc1_r  <= cx0_r * cy1_r;
      pc2_r  <= cx1_r * cy0_r;
      dax2_r <= dax1_r;
      day2_r <= day1_r;
      ax02_r <= ax0_r;
      ay02_r <= ay0_r;
      ccnt_r <= ccnt_nxt;
      cfx_r  <= cfx_nxt;
      cfy_r  <= cfy_nxt;
      csx_r  <= csx_nxt;
      csy_r  <= csy_nxt;
    end
  end

  // classify the pair
  always_comb begin
    m_nxt  = MW'(pm1_r) - MW'(pm2_r);
    n1_nxt = MW'(pn1a_r) - MW'(pn1b_r);
    n2_nxt = MW'(pn2a_r) - MW'(pn2b_r);
    coll   = (pc1_r == pc2_r);
    if (m_nxt < 0) begin
      miss = (n1_nxt > 0) || (n2_nxt > 0) || (n1_nxt < m_nxt) || (n2_nxt < m_nxt);
    end else begin
      miss = (n1_nxt < 0) || (n2_nxt < 0) || (n1_nxt > m_nxt) || (n2_nxt > m_nxt);
    end
    ctl_nxt.valid   = v2_r;
    ctl_nxt.use_div = 1'b0;
    ctl_nxt.count   = segint_pkg::HIT_NONE;
    fx_nxt = '0;
    fy_nxt = '0;
    sx_nxt = '0;
    sy_nxt = '0;
    if (m_nxt == '0) begin
      if (coll) begin
        ctl_nxt.count = ccnt_r;
        fx_nxt = cfx_r;
        fy_nxt = cfy_r;
        sx_nxt = csx_r;
        sy_nxt = csy_r;
      end
    end else if (!miss) begin
      ctl_nxt.use_div = 1'b1;
      ctl_nxt.count   = segint_pkg::HIT_ONE;
    end
  end

  // stage 3: sums and result selection
  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= m_nxt;
      n1_r   <= n1_nxt;
      dax3_r <= dax2_r;
      day3_r <= day2_r;
      ax03_r <= ax02_r;
      ay03_r <= ay02_r;
      fx_r   <= fx_nxt;
      fy_r   <= fy_nxt;
      sx_r   <= sx_nxt;
      sy_r   <= sy_nxt;
    end
  end

  assign ctl = ctl_r;
  assign m   = m_r;
  assign n1  = n1_r;
  assign dax = dax3_r;
  assign day = day3_r;
  assign ax0 = ax03_r;
  assign ay0 = ay03_r;
  assign fx  = fx_r;
  assign fy  = fy_r;
  assign sx  = sx_r;
  assign sy  = sy_r;

endmodule

@@ hdl/segint_div.sv @@
// pipelined signed multiply and divide: n*d/m truncated toward zero, one bit per stage
`timescale 1ns / 1ps

module segint_div #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [2*COORD_BITS+2:0] n,
  input  logic signed [COORD_BITS:0]     d,
  input  logic signed [2*COORD_BITS+2:0] m,
  output logic signed [COORD_BITS:0]     q
);

  localparam int C  = COORD_BITS;
  localparam int D  = C + 1;
  localparam int MW = 2 * D + 1;
  localparam int PW = MW + D;
  localparam int RW = MW + 1;

  // product stage
  logic signed [PW-1:0] prod_r;
  logic signed [MW-1:0] ma_r;

  // magnitude stage
  logic [PW-1:0] nmag_r;
  logic [MW-1:0] dmag_r;
  logic          neg_r;

  // one quotient bit per stage
  logic [RW-1:0] rem_r [C];
  logic [C-1:0]  low_r [C];
  logic [C-1:0]  qb_r  [C];
  logic [MW-1:0] dv_r  [C];
  logic          sg_r  [C];

  // multiply, then take magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= n * PW'(d);
      ma_r   <= m;
      nmag_r <= prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
      dmag_r <= ma_r[MW-1] ? MW'(-ma_r) : MW'(ma_r);
      neg_r  <= prod_r[PW-1] ^ ma_r[MW-1];
    end
  end

  // restoring division stages
  for (genvar k = 0; k < C; k++) begin : g_stage
    logic [RW-1:0] rem_in, t;
    logic [C-1:0]  low_in, q_in;
    logic [MW-1:0] dv_in;
    logic          sg_in;

    if (k == 0) begin : g_first
      assign rem_in = RW'(nmag_r >> C);
      assign low_in = nmag_r[C-1:0];
      assign q_in   = '0;
      assign dv_in  = dmag_r;
      assign sg_in  = neg_r;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = qb_r[k-1];
      assign dv_in  = dv_r[k-1];
      assign sg_in  = sg_r[k-1];
    end

    assign t = {rem_in[RW-2:0], low_in[C-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        if (t >= {1'b0, dv_in}) begin
          rem_r[k] <= t - {1'b0, dv_in};
          qb_r[k]  <= {q_in[C-2:0], 1'b1};
        end else begin
          rem_r[k] <= t;
          qb_r[k]  <= {q_in[C-2:0], 1'b0};
        end
        low_r[k] <= {low_in[C-2:0], 1'b0};
        dv_r[k]  <= dv_in;
        sg_r[k]  <= sg_in;
      end
    end
  end

  // apply the sign
  assign q = sg_r[C-1] ? -D'(qb_r[C-1]) : D'(qb_r[C-1]);

endmodule

@@ hdl/segment_intersection.sv @@
// top level of the integer segment intersection pipeline
`timescale 1ns / 1ps

// Integer intersection of two segments A and B, one pair per transfer.
// Input: in_tvalid/in_tready/in_tdata carry the start and end points of A
// and B. Output: out_tvalid/out_tready/out_tdata carry the hit count and up
// to two points; unused points read zero.
// The path from input transfer to output valid runs through three front
// stages for differences, cross products and classification, two for the
// n1*d product and magnitudes, COORD_BITS restoring-divide stages (one
// quotient bit each), and the output register. Throughput is one pair per
// cycle while the output is not stalled.
// A stalled output holds its register and freezes the whole pipeline;
// in_tready drops in that cycle and no item is lost or repeated.
// Synchronous reset clears all valid bits; no item is in flight after it.
// Zero-length segments are not supported inputs.

module segment_intersection #(
  parameter int COORD_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*COORD_BITS-1:0]                    in_tdata,
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  // hit_count, first_x, first_y, second_x, second_y, zero fill
  output logic [((4*COORD_BITS+2+7)/8)*8-1:0]        out_tdata
);

  localparam int C  = COORD_BITS;
  localparam int D  = C + 1;
  localparam int MW = 2 * D + 1;
  localparam int L  = C + 2;
  localparam int OW = ((4 * C + 2 + 7) / 8) * 8;
  localparam int FW = 4 * C + 2;

  logic en;

  segint_pkg::segint_ctl_t ctl3;
  logic signed [MW-1:0]    m3, n13;
  logic signed [D-1:0]     dax3, day3, qx, qy;
  logic signed [C-1:0]     ax03, ay03, fx3, fy3, sx3, sy3;

  // sideband carried alongside the divider
  segint_pkg::segint_ctl_t side_ctl_r [L];
  logic [C-1:0]            side_ax_r [L];
  logic [C-1:0]            side_ay_r [L];
  logic [C-1:0]            side_fx_r [L];
  logic [C-1:0]            side_fy_r [L];
  logic [C-1:0]            side_sx_r [L];
  logic [C-1:0]            side_sy_r [L];

  // output register
  logic             out_valid_r;
  logic [FW-1:0]    out_data_r;
  logic [FW-1:0]    out_data_nxt;
  logic [C-1:0]     rfx, rfy, rsx, rsy;
  segint_pkg::segint_ctl_t ctl_end;

  // the pipeline advances unless a result waits on a stalled receiver
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  segint_prep #(.COORD_BITS(C)) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .a_start_x (in_tdata[0*C +: C]),
    .a_start_y (in_tdata[1*C +: C]),
    .a_end_x   (in_tdata[2*C +: C]),
    .a_end_y   (in_tdata[3*C +: C]),
    .b_start_x (in_tdata[4*C +: C]),
    .b_start_y (in_tdata[5*C +: C]),
    .b_end_x   (in_tdata[6*C +: C]),
    .b_end_y   (in_tdata[7*C +: C]),
    .ctl       (ctl3),
    .m         (m3),
    .n1        (n13),
    .dax       (dax3),
    .day       (day3),
    .ax0       (ax03),
    .ay0       (ay03),
    .fx        (fx3),
    .fy        (fy3),
    .sx        (sx3),
    .sy        (sy3)
  );

  segint_div #(.COORD_BITS(C)) u_div_x (
    .clk (clk),
    .en  (en),
    .n   (n13),
    .d   (dax3),
    .m   (m3),
    .q   (qx)
  );

  segint_div #(.COORD_BITS(C)) u_div_y (
    .clk (clk),
    .en  (en),
    .n   (n13),
    .d   (day3),
    .m   (m3),
    .q   (qy)
  );

  // sideband control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L; i++) begin
        side_ctl_r[i] <= '0;
      end
    end else if (en) begin
      side_ctl_r[0] <= ctl3;
      for (int i = 1; i < L; i++) begin
        side_ctl_r[i] <= side_ctl_r[i-1];
      end
    end
  end

  // sideband payload
  always_ff @(posedge clk) begin
    if (en) begin
      side_ax_r[0] <= ax03;
      side_ay_r[0] <= ay03;
      side_fx_r[0] <= fx3;
      side_fy_r[0] <= fy3;
      side_sx_r[0] <= sx3;
      side_sy_r[0] <= sy3;
      for (int i = 1; i < L; i++) begin
        side_ax_r[i] <= side_ax_r[i-1];
        side_ay_r[i] <= side_ay_r[i-1];
        side_fx_r[i] <= side_fx_r[i-1];
        side_fy_r[i] <= side_fy_r[i-1];
        side_sx_r[i] <= side_sx_r[i-1];
        side_sy_r[i] <= side_sy_r[i-1];
      end
    end
  end

  // final point: start of A plus the quotient, or the carried result
  always_comb begin
    ctl_end = side_ctl_r[L-1];
    if (ctl_end.use_div) begin
      rfx = side_ax_r[L-1] + qx[C-1:0];
      rfy = side_ay_r[L-1] + qy[C-1:0];
    end else begin
      rfx = side_fx_r[L-1];
      rfy = side_fy_r[L-1];
    end
    rsx = side_sx_r[L-1];
    rsy = side_sy_r[L-1];
    out_data_nxt = {rsy, rsx, rfy, rfx, ctl_end.count};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OW'(out_data_r);

endmodule
